// File: src/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants of the peak envelope downsampler: register
// indexes, register widths and register reset values.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam int unsigned CfgIndexWidth  = 2;
  localparam int unsigned CfgDataWidth   = 17;
  localparam int unsigned ChanCountWidth = 4;
  localparam int unsigned FrameWidth     = 17;
  localparam int unsigned SlackWidth     = 18;
  localparam int unsigned ChanIndexWidth = 3;

  typedef logic [CfgIndexWidth-1:0]  cfg_index_t;
  typedef logic [CfgDataWidth-1:0]   cfg_data_t;
  typedef logic [ChanCountWidth-1:0] chan_count_t;
  typedef logic [FrameWidth-1:0]     frame_t;
  typedef logic [SlackWidth-1:0]     slack_t;
  typedef logic [ChanIndexWidth-1:0] chan_index_t;

  localparam cfg_index_t CFG_CHANNEL_COUNT   = 2'd0;
  localparam cfg_index_t CFG_SRC_FRAME_COUNT = 2'd1;
  localparam cfg_index_t CFG_DST_FRAME_COUNT = 2'd2;

  localparam chan_count_t RESET_CHANNEL_COUNT   = 4'd2;
  localparam frame_t      RESET_SRC_FRAME_COUNT = 17'd4096;
  localparam frame_t      RESET_DST_FRAME_COUNT = 17'd1024;

endpackage

// File: src/peak_envelope_downsampler_core.sv
// ----------------------------------------------------------------------------
// peak_envelope_downsampler_core
// Peak-hold decimator for one chunk of interleaved multichannel samples.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel, frame by frame, channel 0 first, one
// sample per beat. Source frames are grouped into dst_frame_count buckets that
// tile the chunk; at the last frame of each bucket one beat per channel leaves
// on the result channel carrying the sample of largest magnitude, the earlier
// one winning on ties. When dst_frame_count is not below src_frame_count,
// every sample passes through. chunk_end marks the last result of a chunk.
// A sample is taken in every cycle; a result appears in the cycle after its
// sample is accepted, via the single result register. While a result waits
// in that register, a new sample is still accepted if the receiver takes the
// waiting result in the same cycle; a stalled receiver holds off the sender.
// Reset loads the register defaults (2 channels, 4096 source frames, 1024
// destination frames) and restarts the chunk position. Any register write
// also restarts the chunk position.
// ----------------------------------------------------------------------------
module peak_envelope_downsampler_core #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned MAX_FRAMES   = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  ped_pkg::cfg_index_t            cfg_index_i,
  input  ped_pkg::cfg_data_t             cfg_data_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] peak_value_o,
  output ped_pkg::chan_index_t           channel_index_o,
  output logic                           chunk_end_o
);
  import ped_pkg::*;

  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef logic [ChW-1:0]          ch_t;
  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SAMPLE_WIDTH:0]   mag_t;

  chan_count_t chan_count_q;
  frame_t      src_count_q, dst_count_q;
  ch_t         ch_q, ch_d;
  frame_t      frame_q, frame_d;
  slack_t      slack_q, slack_d;
  logic        first_q, first_d;
  sample_t     peak_q [MAX_CHANNELS];

  logic        out_valid_q, out_valid_d;
  sample_t     out_peak_q;
  chan_index_t out_ch_q;
  logic        out_end_q;

  chan_count_t n_eff;
  frame_t      src_eff, dst_eff;
  logic        accept, pass, last_ch, last_frame, ends, emit, take_new;
  slack_t      slack_t_val;
  sample_t     new_peak, out_value;
  mag_t        mag_x, mag_p;

  function automatic mag_t magnitude(sample_t v);
    mag_t ext;
    ext = {v[SAMPLE_WIDTH-1], v};
    return v[SAMPLE_WIDTH-1] ? (mag_t'(0) - ext) : ext;
  endfunction

  always_comb begin
    if (chan_count_q == '0) begin
      n_eff = chan_count_t'(1);
    end else if (32'(chan_count_q) > 32'(MAX_CHANNELS)) begin
      n_eff = chan_count_t'(MAX_CHANNELS);
    end else begin
      n_eff = chan_count_q;
    end
    if (src_count_q == '0) begin
      src_eff = frame_t'(1);
    end else if (32'(src_count_q) > 32'(MAX_FRAMES)) begin
      src_eff = frame_t'(MAX_FRAMES);
    end else begin
      src_eff = src_count_q;
    end
    if (dst_count_q == '0) begin
      dst_eff = frame_t'(1);
    end else if (32'(dst_count_q) > 32'(MAX_FRAMES)) begin
      dst_eff = frame_t'(MAX_FRAMES);
    end else begin
      dst_eff = dst_count_q;
    end
  end

  assign sample_ready_o = !out_valid_q || result_ready_i;
  assign accept         = sample_valid_i && sample_ready_o;
  assign pass           = dst_eff >= src_eff;
  assign last_ch        = (32'(ch_q) + 32'd1) >= 32'(n_eff);
  assign last_frame     = (slack_t'(frame_q) + slack_t'(1)) >= slack_t'(src_eff);

  assign slack_t_val = (slack_q >= slack_t'(dst_eff)) ? (slack_q - slack_t'(dst_eff)) : '0;
  assign ends        = slack_t_val < slack_t'(dst_eff);

  assign mag_x    = magnitude(sample_value_i);
  assign mag_p    = magnitude(peak_q[ch_q]);
  assign take_new = first_q || (mag_x > mag_p);
  assign new_peak = take_new ? sample_value_i : peak_q[ch_q];

  assign emit      = pass || ends;
  assign out_value = pass ? sample_value_i : new_peak;

  always_comb begin
    ch_d    = ch_q;
    frame_d = frame_q;
    slack_d = slack_q;
    first_d = first_q;
    if (accept) begin
      if (!last_ch) begin
        ch_d = ch_q + ch_t'(1);
      end else begin
        ch_d = '0;
        if (pass) begin
          frame_d = last_frame ? '0 : frame_q + frame_t'(1);
        end else if (last_frame) begin
          frame_d = '0;
          slack_d = slack_t'(src_eff);
          first_d = 1'b1;
        end else begin
          frame_d = frame_q + frame_t'(1);
          slack_d = slack_t_val + (ends ? slack_t'(src_eff) : '0);
          first_d = ends;
        end
      end
    end
  end

  always_comb begin
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= RESET_CHANNEL_COUNT;
      src_count_q  <= RESET_SRC_FRAME_COUNT;
      dst_count_q  <= RESET_DST_FRAME_COUNT;
      ch_q         <= '0;
      frame_q      <= '0;
      slack_q      <= slack_t'(RESET_SRC_FRAME_COUNT);
      first_q      <= 1'b1;
      out_valid_q  <= 1'b0;
    end else if (cfg_we_i) begin
      out_valid_q <= out_valid_d;
      case (cfg_index_i)
        CFG_CHANNEL_COUNT: begin
          chan_count_q <= cfg_data_i[ChanCountWidth-1:0];
          ch_q         <= '0;
          frame_q      <= '0;
          first_q      <= 1'b1;
          slack_q      <= slack_t'(src_eff);
        end
        CFG_SRC_FRAME_COUNT: begin
          src_count_q <= cfg_data_i;
          ch_q        <= '0;
          frame_q     <= '0;
          first_q     <= 1'b1;
          if (cfg_data_i == '0) begin
            slack_q <= slack_t'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_FRAMES)) begin
            slack_q <= slack_t'(MAX_FRAMES);
          end else begin
            slack_q <= slack_t'(cfg_data_i);
          end
        end
        CFG_DST_FRAME_COUNT: begin
          dst_count_q <= cfg_data_i;
          ch_q        <= '0;
          frame_q     <= '0;
          first_q     <= 1'b1;
          slack_q     <= slack_t'(src_eff);
        end
        default: begin
          ch_q    <= ch_d;
          frame_q <= frame_d;
          slack_q <= slack_d;
          first_q <= first_d;
        end
      endcase
    end else begin
      ch_q        <= ch_d;
      frame_q     <= frame_d;
      slack_q     <= slack_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !pass) begin
      peak_q[ch_q] <= new_peak;
    end
    if (accept && emit) begin
      out_peak_q <= out_value;
      out_ch_q   <= chan_index_t'(ch_q);
      out_end_q  <= last_ch && last_frame;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign peak_value_o    = out_peak_q;
  assign channel_index_o = out_ch_q;
  assign chunk_end_o     = out_end_q;

endmodule
